// ===== src/bavg3_pkg.sv =====
// Shared constants, types and helper functions of the 3x3 block average downsampler.
package bavg3_pkg;

  localparam int MaxWidth    = 1024;
  localparam int BlockDepth  = MaxWidth / 3;

  localparam int PIX_W       = 8;
  localparam int SUM_W       = 12;
  localparam int WIDTH_W     = 11;
  localparam int AVG_W       = 8;
  localparam int COL_W       = $clog2(MaxWidth);
  localparam int BX_W        = $clog2(BlockDepth + 1);
  localparam int ADDR_W      = $clog2(BlockDepth);

  // Floor division by three through a reciprocal; the shift keeps the error below one third.
  localparam int Div3Shift   = $clog2(MaxWidth) + 2;
  localparam int Div3Mul     = (2 ** Div3Shift + 2) / 3;
  localparam int Div3ProdW   = WIDTH_W + Div3Shift;

  // Floor division by nine of a 12-bit sum: multiply by 7282 and drop 16 bits.
  localparam int Div9Shift   = 16;
  localparam int Div9Mul     = (2 ** Div9Shift + 8) / 9;
  localparam int Div9MulW    = 13;
  localparam int Div9ProdW   = SUM_W + Div9MulW;

  localparam int ResetWidth  = 1000;
  localparam int MinWidth    = 3;

  // Result queue depth; must be a power of two.
  localparam int FifoDepth   = 4;
  localparam int FIFO_PTR_W  = $clog2(FifoDepth);
  localparam int FIFO_CNT_W  = $clog2(FifoDepth + 1);

  typedef logic [PIX_W-1:0]   pix_t;
  typedef logic [SUM_W-1:0]   sum_t;
  typedef logic [WIDTH_W-1:0] width_t;
  typedef logic [AVG_W-1:0]   avg_t;
  typedef logic [COL_W-1:0]   col_t;
  typedef logic [BX_W-1:0]    bx_t;
  typedef logic [ADDR_W-1:0]  addr_t;

  typedef enum logic [1:0] {
    PHASE_TOP,
    PHASE_MID,
    PHASE_BOT
  } phase_t;

  // A finished block total leaving the accumulation stage.
  typedef struct packed {
    logic vld;
    sum_t total;
    bx_t  bx;
    logic row_end;
  } res_t;

  // One entry of the result queue.
  typedef struct packed {
    avg_t average;
    bx_t  block_column;
    logic row_end;
  } out_item_t;

  function automatic width_t clamp_width(width_t w);
    width_t r;
    r = w;
    if (int'(w) < MinWidth) begin
      r = WIDTH_W'(MinWidth);
    end else if (int'(w) > MaxWidth) begin
      r = WIDTH_W'(MaxWidth);
    end
    return r;
  endfunction

  function automatic bx_t blocks_of(width_t w);
    logic [Div3ProdW-1:0] p;
    p = Div3ProdW'(w) * Div3ProdW'(Div3Mul);
    return BX_W'(p >> Div3Shift);
  endfunction

endpackage

// ===== src/bavg3_if.sv =====
// Valid/ready channel interfaces for the pixel input and the block result output.
interface bavg3_in_if;
  import bavg3_pkg::*;

  logic valid;
  logic ready;
  pix_t pixel;
  logic frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface bavg3_out_if;
  import bavg3_pkg::*;

  logic valid;
  logic ready;
  avg_t average;
  bx_t  block_column;
  logic row_end;

  modport source (output valid, output average, output block_column, output row_end,
                  input ready);
  modport sink   (input valid, input average, input block_column, input row_end,
                  output ready);
endinterface

// ===== src/bavg3_sum_mem.sv =====
// Block partial-sum memory: one write port and one registered read port.
module bavg3_sum_mem (
  input  logic           clk,
  input  logic           rd_en,
  input  bavg3_pkg::addr_t rd_addr,
  output bavg3_pkg::sum_t  rd_data,
  input  logic           wr_en,
  input  bavg3_pkg::addr_t wr_addr,
  input  bavg3_pkg::sum_t  wr_data
);
  import bavg3_pkg::*;

  sum_t mem [BlockDepth];
  sum_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
endmodule

// ===== src/bavg3_accum.sv =====
// Position tracking, segment summing and read-modify-write of the block sums.
module bavg3_accum (
  input  logic              clk,
  input  logic              rst_n,
  bavg3_in_if.sink          in_ch,
  input  logic              cfg_we,
  input  bavg3_pkg::width_t cfg_wdata,
  input  logic              accept_ok,
  output logic              mem_rd_en,
  output bavg3_pkg::addr_t  mem_rd_addr,
  input  bavg3_pkg::sum_t   mem_rd_data,
  output logic              mem_wr_en,
  output bavg3_pkg::addr_t  mem_wr_addr,
  output bavg3_pkg::sum_t   mem_wr_data,
  output bavg3_pkg::res_t   res
);
  import bavg3_pkg::*;

  width_t width_r, width_nxt;
  bx_t    blocks_r, blocks_nxt;
  col_t   col_r, col_nxt;
  bx_t    bx_r, bx_nxt;
  logic [1:0] sub_r, sub_nxt;
  phase_t phase_r, phase_nxt;
  sum_t   run_r, run_nxt;

  logic   b_vld_r, b_vld_nxt;
  phase_t b_phase_r;
  bx_t    b_bx_r;
  sum_t   b_seg_r;
  logic   b_end_r;

  col_t   col_c;
  bx_t    bx_c;
  logic [1:0] sub_c;
  phase_t phase_c;
  sum_t   run_c;
  sum_t   run_sum;
  logic   active;
  logic   seg_done;
  logic   line_done;
  logic   acc;
  logic   row_end_c;
  logic [COL_W:0] col_inc;
  width_t cw;
  sum_t   sum_b;

  assign in_ch.ready = accept_ok;
  assign acc         = in_ch.valid && accept_ok;

  always_comb begin
    col_c   = col_r;
    bx_c    = bx_r;
    sub_c   = sub_r;
    phase_c = phase_r;
    run_c   = run_r;
    if (in_ch.frame_start) begin
      col_c   = '0;
      bx_c    = '0;
      sub_c   = '0;
      phase_c = PHASE_TOP;
      run_c   = '0;
    end

    active    = bx_c < blocks_r;
    run_sum   = (sub_c == 2'd0) ? SUM_W'(in_ch.pixel) : run_c + SUM_W'(in_ch.pixel);
    seg_done  = active && (sub_c == 2'd2);
    row_end_c = (bx_c + BX_W'(1)) == blocks_r;
    col_inc   = {1'b0, col_c} + (COL_W + 1)'(1);
    line_done = col_inc >= (COL_W + 1)'(width_r);

    col_nxt   = col_r;
    bx_nxt    = bx_r;
    sub_nxt   = sub_r;
    phase_nxt = phase_r;
    run_nxt   = run_r;
    if (acc) begin
      run_nxt = active ? run_sum : run_c;
      if (line_done) begin
        col_nxt = '0;
        bx_nxt  = '0;
        sub_nxt = '0;
        case (phase_c)
          PHASE_TOP: phase_nxt = PHASE_MID;
          PHASE_MID: phase_nxt = PHASE_BOT;
          default:   phase_nxt = PHASE_TOP;
        endcase
      end else begin
        col_nxt   = col_inc[COL_W-1:0];
        phase_nxt = phase_c;
        if (sub_c == 2'd2) begin
          sub_nxt = '0;
          bx_nxt  = bx_c + BX_W'(1);
        end else begin
          sub_nxt = sub_c + 2'd1;
          bx_nxt  = bx_c;
        end
      end
    end

    b_vld_nxt = acc && seg_done;

    cw         = clamp_width(cfg_wdata);
    width_nxt  = cfg_we ? cw : width_r;
    blocks_nxt = cfg_we ? blocks_of(cw) : blocks_r;
  end

  // The stored sum of a block is only fetched for the middle and bottom lines.
  assign mem_rd_en   = b_vld_nxt && (phase_c != PHASE_TOP);
  assign mem_rd_addr = ADDR_W'(bx_c);

  // Two segment completions of the same block are at least a full line apart, so a
  // read never meets a pending write to the same entry.
  assign sum_b       = mem_rd_data + b_seg_r;
  assign mem_wr_en   = b_vld_r && (b_phase_r != PHASE_BOT);
  assign mem_wr_addr = ADDR_W'(b_bx_r);
  assign mem_wr_data = (b_phase_r == PHASE_TOP) ? b_seg_r : sum_b;

  assign res.vld     = b_vld_r && (b_phase_r == PHASE_BOT);
  assign res.total   = sum_b;
  assign res.bx      = b_bx_r;
  assign res.row_end = b_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_W'(ResetWidth);
      blocks_r <= blocks_of(WIDTH_W'(ResetWidth));
      col_r    <= '0;
      bx_r     <= '0;
      sub_r    <= '0;
      phase_r  <= PHASE_TOP;
      run_r    <= '0;
      b_vld_r  <= 1'b0;
    end else begin
      width_r  <= width_nxt;
      blocks_r <= blocks_nxt;
      col_r    <= col_nxt;
      bx_r     <= bx_nxt;
      sub_r    <= sub_nxt;
      phase_r  <= phase_nxt;
      run_r    <= run_nxt;
      b_vld_r  <= b_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b_vld_nxt) begin
      b_phase_r <= phase_c;
      b_bx_r    <= bx_c;
      b_seg_r   <= run_sum;
      b_end_r   <= row_end_c;
    end
  end
endmodule

// ===== src/bavg3_out.sv =====
// Divide-by-nine stage and result queue in front of the output channel.
module bavg3_out (
  input  logic            clk,
  input  logic            rst_n,
  input  bavg3_pkg::res_t res,
  output logic            accept_ok,
  bavg3_out_if.source     out_ch
);
  import bavg3_pkg::*;

  logic  c_vld_r;
  sum_t  c_total_r;
  bx_t   c_bx_r;
  logic  c_end_r;

  out_item_t fifo_mem [FifoDepth];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;

  logic [Div9ProdW-1:0] prod;
  out_item_t            push_item;
  logic                 push;
  logic                 pop;
  logic [FIFO_CNT_W:0]  pending;

  assign prod = Div9ProdW'(c_total_r) * Div9ProdW'(Div9Mul);
  assign push_item.average      = prod[Div9Shift +: AVG_W];
  assign push_item.block_column = c_bx_r;
  assign push_item.row_end      = c_end_r;

  assign push = c_vld_r;
  assign pop  = out_ch.valid && out_ch.ready;

  // Every result that may still arrive has a queue entry reserved for it.
  assign pending   = (FIFO_CNT_W + 1)'(cnt_r) + (FIFO_CNT_W + 1)'(c_vld_r)
                   + (FIFO_CNT_W + 1)'(res.vld);
  assign accept_ok = pending < (FIFO_CNT_W + 1)'(FifoDepth);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + FIFO_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + FIFO_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
  end

  assign out_ch.valid        = cnt_r != '0;
  assign out_ch.average      = fifo_mem[rd_ptr_r].average;
  assign out_ch.block_column = fifo_mem[rd_ptr_r].block_column;
  assign out_ch.row_end      = fifo_mem[rd_ptr_r].row_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r  <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      c_vld_r  <= res.vld;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.vld) begin
      c_total_r <= res.total;
      c_bx_r    <= res.bx;
      c_end_r   <= res.row_end;
    end
    if (push) begin
      fifo_mem[wr_ptr_r] <= push_item;
    end
  end
endmodule

// ===== src/block_average_downsample_3x3.sv =====
// Top level of the 3x3 block average downsampler.
//
// Grey pixels arrive in raster order, one per transfer, and the block takes one pixel every
// clock cycle unless stalled. Each line of line_width pixels (clamped to 3..1024) is cut into
// blocks of three columns; pixels past the last whole block are dropped. The three-pixel
// segment sums of the first two lines of a block row are kept per block in a 341 x 12-bit
// memory with one write port and a registered read port. On the third line the pixel that
// finishes a block yields one result: the floor of the nine-pixel sum divided by nine, its
// block column, and a row_end mark on the last block of the row. The stored sum is read into
// a register beside the registered segment sum; the two are added, the total is registered and
// divided by nine, and the result waits in a four-entry queue. The input stalls only when that
// queue and the stages ahead of it could otherwise overflow, so with the output side ready the
// sustained rate is one pixel per cycle. The memory has no clearing pass; its entries are
// always written on the top line of a block row before they are read. A frame_start on a pixel
// restarts the position at row 0, column 0 with that pixel. line_width is written through
// cfg_we and cfg_wdata and must only change while no results are still in flight.
module block_average_downsample_3x3 (
  input  logic              clk,
  input  logic              rst_n,
  bavg3_in_if.sink          in_ch,
  bavg3_out_if.source       out_ch,
  input  logic              cfg_we,
  input  bavg3_pkg::width_t cfg_wdata
);
  import bavg3_pkg::*;

  logic  accept_ok;
  res_t  res;
  logic  mem_rd_en;
  addr_t mem_rd_addr;
  sum_t  mem_rd_data;
  logic  mem_wr_en;
  addr_t mem_wr_addr;
  sum_t  mem_wr_data;

  // Front end: counts the position, sums segments and updates the stored block sums.
  bavg3_accum u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .accept_ok   (accept_ok),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .res         (res)
  );

  // Per-block partial sums of the current block row.
  bavg3_sum_mem u_sum_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  // Back end: divides finished totals by nine and queues the results.
  bavg3_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .accept_ok (accept_ok),
    .out_ch    (out_ch)
  );
endmodule

// ===== src/bavg3_chk.sv =====
// Port-level checker for the 3x3 block average downsampler and its bind statement.
module bavg3_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input bavg3_pkg::avg_t   out_average,
  input bavg3_pkg::bx_t    out_block_column,
  input logic              out_row_end
);
  import bavg3_pkg::*;

  logic in_xfer;
  assign in_xfer = in_valid && in_ready;

  // A result held back by the sink keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_average)
      && $stable(out_block_column) && $stable(out_row_end))
    else $error("result changed while stalled");

  // Reset empties the result queue.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A result appearing on an empty output follows the transfer of the pixel that completed it.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_xfer, 3))
    else $error("result without a matching pixel transfer");

  // Coming out of reset, nothing is in flight, so the input is open.
  a_ready_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> in_ready)
    else $error("input not ready after reset");
endmodule

bind block_average_downsample_3x3 bavg3_chk u_bavg3_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_average      (out_ch.average),
  .out_block_column (out_ch.block_column),
  .out_row_end      (out_ch.row_end)
);
